### design/c8ic_pkg.sv
// shared constants and types for the chip8 interpreter core
package c8ic_pkg;

   localparam int RAM_BYTES = 4096;
   localparam int RAM_AW = 12;
   localparam int SCREEN_W = 64;
   localparam int SCREEN_H = 32;
   localparam int FONT_BYTES = 80;

   typedef enum logic [2:0] {
      OP_STEP = 3'd0,
      OP_TICK = 3'd1,
      OP_KEY = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ = 3'd4,
      OP_ROW = 3'd5
   } op_type;

   localparam logic [15:0] OPC_CLS = 16'h00E0;
   localparam logic [15:0] OPC_RET = 16'h00EE;

   localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

endpackage

### design/chip8_interpreter_core.sv
// chip8 interpreter core: sequencer, ram, display, registers and timers
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  req_tuser operation, req_tdata fields
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata result fields
// csr      in   csr_tvalid/csr_tready  csr_tdata start address
//
// after reset a clearing pass loads the font into ram while no request
// is taken. a step request fetches the opcode, reads its registers and
// executes; a draw goes sprite row by sprite row, a load or store goes
// register by register, and bcd works by repeated subtraction. the
// single ram port is why draw, load and store go one byte at a time. a
// finished result waits in the output register while the next request is taken.
module chip8_interpreter_core
   import c8ic_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // operation
   input  logic [2:0]   req_tuser,
   // address, data_byte, key_index, key_down, random_byte, screen_row
   input  logic [39:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // read_data, row_pixels, program_counter, last_opcode, sound_on,
   // waiting_key, pixel_collision
   output logic [103:0] rsp_tdata,
   input  logic         csr_tvalid,
   output logic         csr_tready,
   // start_address
   input  logic [15:0]  csr_tdata
);

   localparam int SI = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SPW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_RUN, S_RDWAIT, S_FETCH1, S_FETCH2, S_RDX, S_RDY,
      S_EXEC, S_DRAW_RD, S_DRAW_WR, S_BCD, S_BCD_WR, S_STORE, S_LOAD_RD,
      S_LOAD_WR, S_DONE
   } state_type;

   state_type state_ff;
   logic [RAM_AW-1:0] clr_ff;
   logic [2:0] opsel_ff;
   logic [11:0] addr_ff;
   logic [7:0] data_ff, rnd_ff;
   logic [3:0] kidx_ff;
   logic kdown_ff;
   logic [4:0] row_ff;
   logic [11:0] pc_ff;
   logic [15:0] i_ff;
   logic [SPW-1:0] sp_ff;
   logic [15:0] keys_ff;
   logic [7:0] dt_ff, st_ff;
   logic [7:0] regs_ff [16];
   logic [SCREEN_W-1:0] screen_ff [SCREEN_H];
   logic [11:0] stack_ff [STACK_DEPTH];
   logic [7:0] mem [RAM_BYTES];
   logic [7:0] ram_q_ff;
   logic [7:0] hi_ff;
   logic [15:0] word_ff;
   logic [7:0] vx_ff, vy_ff;
   logic [3:0] cnt_ff;
   logic hit_ff, wait_ff;
   logic [7:0] rd_ff;
   logic [63:0] pix_ff;
   logic [7:0] rem_ff;
   logic [1:0] hund_ff;
   logic [3:0] tens_ff;
   logic rsp_valid_ff;
   logic [103:0] rsp_data_ff;

   logic [RAM_AW-1:0] ram_addr;
   logic ram_we;
   logic [7:0] ram_wd;
   logic [3:0] reg_sel;
   logic [7:0] reg_q;
   logic [3:0] x_nib, y_nib, n_nib;
   logic [7:0] nn;
   logic [11:0] nnn;
   logic [11:0] i_cnt;
   logic [63:0] sprite_mask;
   logic [4:0] draw_y;
   logic [4:0] key_first;
   logic [8:0] sum9;

   assign x_nib = word_ff[11:8];
   assign y_nib = word_ff[7:4];
   assign n_nib = word_ff[3:0];
   assign nn = word_ff[7:0];
   assign nnn = word_ff[11:0];
   assign i_cnt = i_ff[11:0] + {8'd0, cnt_ff};
   assign draw_y = vy_ff[4:0] + {1'b0, cnt_ff};
   assign req_tready = (state_ff == S_IDLE);
   assign csr_tready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign reg_q = regs_ff[reg_sel];
   assign sum9 = {1'b0, vx_ff} + {1'b0, vy_ff};

   always_comb begin
      logic [63:0] m;
      logic [6:0] back;
      m = 64'd0;
      for (int c = 0; c < 8; c++) begin
         m[c] = ram_q_ff[7 - c];
      end
      back = 7'd64 - {1'b0, vx_ff[5:0]};
      sprite_mask = (m << vx_ff[5:0]) | (m >> back);
   end

   always_comb begin
      key_first = 5'd16;
      for (int k = 15; k >= 0; k--) begin
         if (keys_ff[k]) begin
            key_first = 5'(k);
         end
      end
   end

   always_comb begin
      reg_sel = x_nib;
      unique case (state_ff)
         S_RDY: reg_sel = (word_ff[15:12] == 4'hB) ? 4'd0 : y_nib;
         S_STORE: reg_sel = cnt_ff;
         default: reg_sel = x_nib;
      endcase
   end

   always_comb begin
      ram_addr = i_cnt;
      ram_we = 1'b0;
      ram_wd = 8'd0;
      unique case (state_ff)
         S_CLEAR: begin
            ram_addr = clr_ff;
            ram_we = 1'b1;
            ram_wd = (clr_ff < RAM_AW'(FONT_BYTES)) ? FONT_ROM[clr_ff[6:0]] : 8'd0;
         end
         S_RUN: begin
            ram_addr = (opsel_ff == OP_STEP) ? pc_ff : addr_ff;
            ram_we = (opsel_ff == OP_WRITE);
            ram_wd = data_ff;
         end
         S_FETCH1: ram_addr = pc_ff + 12'd1;
         S_BCD_WR: begin
            ram_we = 1'b1;
            ram_wd = (cnt_ff == 4'd0) ? {6'd0, hund_ff}
                   : (cnt_ff == 4'd1) ? {4'd0, tens_ff} : rem_ff;
         end
         S_STORE: begin
            ram_we = 1'b1;
            ram_wd = reg_q;
         end
         default: ram_addr = i_cnt;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         mem[ram_addr] <= ram_wd;
      end
      ram_q_ff <= mem[ram_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         pc_ff <= 12'd512;
         i_ff <= '0;
         sp_ff <= '0;
         keys_ff <= '0;
         dt_ff <= '0;
         st_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < 16; r++) regs_ff[r] <= '0;
         for (int r = 0; r < SCREEN_H; r++) screen_ff[r] <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == RAM_AW'(RAM_BYTES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  opsel_ff <= req_tuser;
                  addr_ff <= req_tdata[11:0];
                  data_ff <= req_tdata[19:12];
                  kidx_ff <= req_tdata[23:20];
                  kdown_ff <= req_tdata[24];
                  rnd_ff <= req_tdata[32:25];
                  row_ff <= req_tdata[37:33];
                  word_ff <= '0;
                  rd_ff <= '0;
                  pix_ff <= '0;
                  hit_ff <= 1'b0;
                  wait_ff <= 1'b0;
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               state_ff <= S_DONE;
               case (opsel_ff)
                  OP_STEP: state_ff <= S_FETCH1;
                  OP_TICK: begin
                     if (dt_ff != 8'd0) dt_ff <= dt_ff - 8'd1;
                     if (st_ff != 8'd0) st_ff <= st_ff - 8'd1;
                  end
                  OP_KEY: keys_ff[kidx_ff] <= kdown_ff;
                  OP_READ: state_ff <= S_RDWAIT;
                  OP_ROW: pix_ff <= screen_ff[row_ff];
                  default: ;
               endcase
            end
            S_RDWAIT: begin
               rd_ff <= ram_q_ff;
               state_ff <= S_DONE;
            end
            S_FETCH1: begin
               hi_ff <= ram_q_ff;
               state_ff <= S_FETCH2;
            end
            S_FETCH2: begin
               word_ff <= {hi_ff, ram_q_ff};
               pc_ff <= pc_ff + 12'd2;
               state_ff <= S_RDX;
            end
            S_RDX: begin
               vx_ff <= reg_q;
               state_ff <= S_RDY;
            end
            S_RDY: begin
               vy_ff <= reg_q;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               state_ff <= S_DONE;
               cnt_ff <= '0;
               case (word_ff[15:12])
                  4'h0: begin
                     if (word_ff == OPC_CLS) begin
                        for (int r = 0; r < SCREEN_H; r++) screen_ff[r] <= '0;
                     end else if (word_ff == OPC_RET && sp_ff != '0) begin
                        sp_ff <= sp_ff - 1'b1;
                        pc_ff <= stack_ff[SI'(sp_ff - 1'b1)];
                     end
                  end
                  4'h1: pc_ff <= nnn;
                  4'h2: begin
                     if (sp_ff < SPW'(STACK_DEPTH)) begin
                        stack_ff[SI'(sp_ff)] <= pc_ff;
                        sp_ff <= sp_ff + 1'b1;
                     end
                     pc_ff <= nnn;
                  end
                  4'h3: if (vx_ff == nn) pc_ff <= pc_ff + 12'd2;
                  4'h4: if (vx_ff != nn) pc_ff <= pc_ff + 12'd2;
                  4'h5: if (vx_ff == vy_ff) pc_ff <= pc_ff + 12'd2;
                  4'h6: regs_ff[x_nib] <= nn;
                  4'h7: regs_ff[x_nib] <= vx_ff + nn;
                  4'h8: begin
                     case (n_nib)
                        4'h0: regs_ff[x_nib] <= vy_ff;
                        4'h1: regs_ff[x_nib] <= vx_ff | vy_ff;
                        4'h2: regs_ff[x_nib] <= vx_ff & vy_ff;
                        4'h3: regs_ff[x_nib] <= vx_ff ^ vy_ff;
                        4'h4: begin
                           regs_ff[x_nib] <= sum9[7:0];
                           regs_ff[15] <= {7'd0, sum9[8]};
                        end
                        4'h5: begin
                           regs_ff[x_nib] <= vx_ff - vy_ff;
                           regs_ff[15] <= {7'd0, vx_ff >= vy_ff};
                        end
                        4'h6: begin
                           regs_ff[x_nib] <= vx_ff >> 1;
                           regs_ff[15] <= {7'd0, vx_ff[0]};
                        end
                        4'h7: begin
                           regs_ff[x_nib] <= vy_ff - vx_ff;
                           regs_ff[15] <= {7'd0, vy_ff >= vx_ff};
                        end
                        4'hE: begin
                           regs_ff[x_nib] <= vx_ff << 1;
                           regs_ff[15] <= {7'd0, vx_ff[7]};
                        end
                        default: ;
                     endcase
                  end
                  4'h9: if (vx_ff != vy_ff) pc_ff <= pc_ff + 12'd2;
                  4'hA: i_ff <= {4'd0, nnn};
                  4'hB: pc_ff <= {4'd0, vy_ff} + nnn;
                  4'hC: regs_ff[x_nib] <= rnd_ff & nn;
                  4'hD: begin
                     if (n_nib == 4'd0) regs_ff[15] <= '0;
                     else state_ff <= S_DRAW_RD;
                  end
                  4'hE: begin
                     if (nn == 8'h9E && keys_ff[vx_ff[3:0]]) pc_ff <= pc_ff + 12'd2;
                     if (nn == 8'hA1 && !keys_ff[vx_ff[3:0]]) pc_ff <= pc_ff + 12'd2;
                  end
                  default: begin
                     case (nn)
                        8'h07: regs_ff[x_nib] <= dt_ff;
                        8'h0A: begin
                           if (key_first[4]) begin
                              pc_ff <= pc_ff - 12'd2;
                              wait_ff <= 1'b1;
                           end else begin
                              regs_ff[x_nib] <= {4'd0, key_first[3:0]};
                           end
                        end
                        8'h15: dt_ff <= vx_ff;
                        8'h18: st_ff <= vx_ff;
                        8'h1E: i_ff <= i_ff + {8'd0, vx_ff};
                        8'h29: i_ff <= ({8'd0, vx_ff} << 2) + {8'd0, vx_ff};
                        8'h33: begin
                           rem_ff <= vx_ff;
                           hund_ff <= '0;
                           tens_ff <= '0;
                           state_ff <= S_BCD;
                        end
                        8'h55: state_ff <= S_STORE;
                        8'h65: state_ff <= S_LOAD_RD;
                        default: ;
                     endcase
                  end
               endcase
            end
            S_DRAW_RD: state_ff <= S_DRAW_WR;
            S_DRAW_WR: begin
               screen_ff[draw_y] <= screen_ff[draw_y] ^ sprite_mask;
               hit_ff <= hit_ff | (|(screen_ff[draw_y] & sprite_mask));
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == n_nib - 4'd1) begin
                  regs_ff[15] <= {7'd0, hit_ff | (|(screen_ff[draw_y] & sprite_mask))};
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_DRAW_RD;
               end
            end
            S_BCD: begin
               if (rem_ff >= 8'd100) begin
                  rem_ff <= rem_ff - 8'd100;
                  hund_ff <= hund_ff + 1'b1;
               end else if (rem_ff >= 8'd10) begin
                  rem_ff <= rem_ff - 8'd10;
                  tens_ff <= tens_ff + 1'b1;
               end else begin
                  state_ff <= S_BCD_WR;
               end
            end
            S_BCD_WR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 4'd2) state_ff <= S_DONE;
            end
            S_STORE: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == x_nib) state_ff <= S_DONE;
            end
            S_LOAD_RD: state_ff <= S_LOAD_WR;
            S_LOAD_WR: begin
               regs_ff[cnt_ff] <= ram_q_ff;
               cnt_ff <= cnt_ff + 1'b1;
               state_ff <= (cnt_ff == x_nib) ? S_DONE : S_LOAD_RD;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff <= {1'b0, hit_ff, wait_ff, st_ff != 8'd0, word_ff,
                                  pc_ff, pix_ff, rd_ff};
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (csr_tvalid) begin
            pc_ff <= csr_tdata[11:0];
         end
      end
   end

endmodule
